### design/lr_pkg.sv
// lr_pkg: shared types and constants for the line rasterizer
// holds the command and pixel payload structs and the step-unit control struct
// no dependencies
package lr_pkg;

	// fixed field widths of the command and pixel payloads
	localparam int COORD_W = 6;
	localparam int COLOR_W = 32;

	// default coordinate width used by the datapath
	localparam int COORD_BITS_DEF = 6;

	// one line command
	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic [COLOR_W-1:0] draw_color;
	} line_cmd_t;

	// one pixel write
	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [COLOR_W-1:0] pixel_color;
		logic               last_pixel;
	} pixel_t;

	// control from the sequencer to the step unit
	typedef struct packed {
		logic load;
		logic step;
	} dda_ctl_t;

endpackage

### design/lr_dda.sv
// lr_dda: exact-integer step unit for the line rasterizer
// keeps major coord, minor quotient, remainder; one step per cycle with ctl.step
// depends on lr_pkg
module lr_dda #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  lr_pkg::dda_ctl_t      ctl,
	input  logic [COORD_BITS-1:0] m0,
	input  logic [COORD_BITS-1:0] m1,
	input  logic [COORD_BITS-1:0] n0,
	input  logic [COORD_BITS-1:0] n1,
	output logic [COORD_BITS-1:0] m,
	output logic [COORD_BITS-1:0] n,
	output logic                  last
);
	import lr_pkg::*;

	logic [COORD_BITS-1:0]      m_q;
	logic [COORD_BITS-1:0]      m1_q;
	logic [COORD_BITS-1:0]      q_q;
	logic [COORD_BITS-1:0]      r_q;
	logic [COORD_BITS-1:0]      span_q;
	logic signed [COORD_BITS:0] delta_q;

	logic signed [COORD_BITS+1:0] sum;
	logic signed [COORD_BITS+1:0] span_ext;
	logic signed [COORD_BITS+1:0] r_fix;
	logic [COORD_BITS-1:0]        r_next;
	logic [COORD_BITS-1:0]        q_next;

	// remainder update: add the minor delta, then one correction by the span
	always_comb begin
		sum      = $signed({2'b00, r_q}) + $signed({delta_q[COORD_BITS], delta_q});
		span_ext = $signed({2'b00, span_q});
		r_fix    = sum;
		q_next   = q_q;
		if (!delta_q[COORD_BITS] && (sum >= span_ext)) begin
			r_fix  = sum - span_ext;
			q_next = q_q + 1'b1;
		end else if (delta_q[COORD_BITS] && sum[COORD_BITS+1]) begin
			r_fix  = sum + span_ext;
			q_next = q_q - 1'b1;
		end
		r_next = r_fix[COORD_BITS-1:0];
	end

	// step registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			m_q     <= m0;
			m1_q    <= m1;
			q_q     <= n0;
			r_q     <= '0;
			span_q  <= m1 - m0;
			delta_q <= $signed({1'b0, n1}) - $signed({1'b0, n0});
		end else if (ctl.step) begin
			m_q <= m_q + 1'b1;
			q_q <= q_next;
			r_q <= r_next;
		end
	end

	assign m    = m_q;
	assign n    = q_q;
	assign last = (m_q == m1_q);

endmodule

### design/line_rasterizer.sv
// line_rasterizer: top level, command capture, axis setup and pixel output register
// uses lr_dda for the exact minor-coordinate stepping
// depends on lr_pkg
//
// Takes one line command per transfer and emits one pixel transfer per major-axis
// step, span+1 pixels in all, the last one marked. The column is the major axis
// unless the row extent is larger; pixels come out in ascending major order. A
// command passes through capture and then setup (extents, steep test, end point
// ordering), then the step unit produces one pixel per cycle while the output
// side takes them.
// The step unit (one add and one span correction per cycle) sets the pixel rate while the output is not stalled.
// cmd_ready is high only between commands; the last pixel may still sit in the
// output register while the next command is taken.
module line_rasterizer #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  lr_pkg::line_cmd_t cmd,
	output logic              pix_valid,
	input  logic              pix_ready,
	output lr_pkg::pixel_t    pix
);
	import lr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SETUP = 3'b010,
		S_RUN   = 3'b100
	} state_t;

	state_t state_q, state_d;

	logic [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q;
	logic [COLOR_W-1:0]    color_q;
	logic                  steep_q;

	logic [COORD_BITS-1:0] dx, dy;
	logic                  steep;
	logic [COORD_BITS-1:0] pm0, pm1, pn0, pn1;
	logic [COORD_BITS-1:0] m0, m1, n0, n1;
	logic                  swap;

	dda_ctl_t              dda_ctl;
	logic [COORD_BITS-1:0] cur_m, cur_n;
	logic                  cur_last;

	pixel_t pix_q;
	logic   pix_valid_q;
	logic   slot_free;
	logic   emit;

	assign cmd_ready = (state_q == S_IDLE);
	assign slot_free = !pix_valid_q || pix_ready;
	assign emit      = (state_q == S_RUN) && slot_free;

	// command capture, low coordinate bits only
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			ax_q    <= cmd.start_x[COORD_BITS-1:0];
			ay_q    <= cmd.start_y[COORD_BITS-1:0];
			bx_q    <= cmd.end_x[COORD_BITS-1:0];
			by_q    <= cmd.end_y[COORD_BITS-1:0];
			color_q <= cmd.draw_color;
		end
	end

	// axis setup: extents, steep test and ordering of the end points
	always_comb begin
		dx    = (ax_q > bx_q) ? (ax_q - bx_q) : (bx_q - ax_q);
		dy    = (ay_q > by_q) ? (ay_q - by_q) : (by_q - ay_q);
		steep = (dx < dy);
		pm0   = steep ? ay_q : ax_q;
		pn0   = steep ? ax_q : ay_q;
		pm1   = steep ? by_q : bx_q;
		pn1   = steep ? bx_q : by_q;
		swap  = (pm0 > pm1);
		m0    = swap ? pm1 : pm0;
		n0    = swap ? pn1 : pn0;
		m1    = swap ? pm0 : pm1;
		n1    = swap ? pn0 : pn1;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SETUP) begin
			steep_q <= steep;
		end
	end

	assign dda_ctl.load = (state_q == S_SETUP);
	assign dda_ctl.step = emit;

	lr_dda #(
		.COORD_BITS(COORD_BITS)
	) u_dda (
		.clk  (clk),
		.ctl  (dda_ctl),
		.m0   (m0),
		.m1   (m1),
		.n0   (n0),
		.n1   (n1),
		.m    (cur_m),
		.n    (cur_n),
		.last (cur_last)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) state_d = S_SETUP;
			end
			S_SETUP: state_d = S_RUN;
			S_RUN: begin
				if (slot_free && cur_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (emit) begin
			pix_valid_q <= 1'b1;
		end else if (pix_ready) begin
			pix_valid_q <= 1'b0;
		end
	end

	// output register payload, back in column/row order
	always_ff @(posedge clk) begin
		if (emit) begin
			pix_q.pixel_x     <= steep_q ? COORD_W'(cur_n) : COORD_W'(cur_m);
			pix_q.pixel_y     <= steep_q ? COORD_W'(cur_m) : COORD_W'(cur_n);
			pix_q.pixel_color <= color_q;
			pix_q.last_pixel  <= cur_last;
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

endmodule

### tb/line_rasterizer_test.sv
// line_rasterizer_test: self-checking testbench for the line rasterizer
// predicts every pixel transfer of each line command and checks them in order
// depends on lr_pkg and line_rasterizer
module line_rasterizer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lr_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_CYCLES = 80;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_ready;
	line_cmd_t cmd;
	logic      pix_valid;
	logic      pix_ready;
	pixel_t    pix;

	// pixels predicted for accepted commands, oldest first
	pixel_t due_pixels[$];
	int     mismatches = 0;
	int     cycles = 0;
	int     send_idle = 0;
	int     recv_idle = 0;

	line_rasterizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("line_rasterizer test failed");
			$finish;
		end
	end

	// walk the major axis and queue one pixel per step
	function automatic void trace_line(line_cmd_t c);
		int     ax = int'(c.start_x);
		int     ay = int'(c.start_y);
		int     bx = int'(c.end_x);
		int     by = int'(c.end_y);
		int     dx = (ax > bx) ? ax - bx : bx - ax;
		int     dy = (ay > by) ? ay - by : by - ay;
		bit     steep = (dx < dy);
		int     m0, n0, m1, n1, t, span, n;
		pixel_t px;
		if (steep) begin
			m0 = ay; n0 = ax; m1 = by; n1 = bx;
		end else begin
			m0 = ax; n0 = ay; m1 = bx; n1 = by;
		end
		// step upward along the major axis
		if (m0 > m1) begin
			t = m0; m0 = m1; m1 = t;
			t = n0; n0 = n1; n1 = t;
		end
		span = m1 - m0;
		for (int m = m0; m <= m1; m++) begin
			// exact minor coordinate, floor of the weighted average
			n = (span == 0) ? n0 : (n0 * (m1 - m) + n1 * (m - m0)) / span;
			px.pixel_x     = steep ? n[COORD_W-1:0] : m[COORD_W-1:0];
			px.pixel_y     = steep ? m[COORD_W-1:0] : n[COORD_W-1:0];
			px.pixel_color = c.draw_color;
			px.last_pixel  = (m == m1);
			due_pixels.push_back(px);
		end
	endfunction

	// receiver stalls at random
	always @(negedge clk) begin
		pix_ready = ($urandom_range(0, 99) >= recv_idle);
	end

	// check each pixel transfer against the oldest prediction
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && pix_valid && pix_ready) begin
			if (due_pixels.size() == 0) begin
				$display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b", $time,
					pix.pixel_x, pix.pixel_y, pix.pixel_color, pix.last_pixel);
				mismatches++;
			end else begin
				want = due_pixels.pop_front();
				if (pix.pixel_x !== want.pixel_x) begin
					$display("%0t: pixel_x expected %0d got %0d", $time,
						want.pixel_x, pix.pixel_x);
					mismatches++;
				end
				if (pix.pixel_y !== want.pixel_y) begin
					$display("%0t: pixel_y expected %0d got %0d", $time,
						want.pixel_y, pix.pixel_y);
					mismatches++;
				end
				if (pix.pixel_color !== want.pixel_color) begin
					$display("%0t: pixel_color expected %h got %h", $time,
						want.pixel_color, pix.pixel_color);
					mismatches++;
				end
				if (pix.last_pixel !== want.last_pixel) begin
					$display("%0t: last_pixel expected %b got %b", $time,
						want.last_pixel, pix.last_pixel);
					mismatches++;
				end
			end
		end
	end

	// one command transfer, entered and left at a falling edge
	task automatic send_line(input line_cmd_t c);
		while ($urandom_range(0, 99) < send_idle) @(negedge clk);
		cmd = c;
		cmd_valid = 1'b1;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		trace_line(c);
		@(negedge clk);
		cmd_valid = 1'b0;
	endtask

	task automatic send_points(input int x0, input int y0, input int x1, input int y1,
		input logic [COLOR_W-1:0] color);
		line_cmd_t c;
		c.start_x = COORD_W'(x0);
		c.start_y = COORD_W'(y0);
		c.end_x = COORD_W'(x1);
		c.end_y = COORD_W'(y1);
		c.draw_color = color;
		send_line(c);
	endtask

	task automatic wait_drained();
		while (due_pixels.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// random line, biased toward the shapes with edge behavior
	function automatic line_cmd_t random_line();
		line_cmd_t c;
		int        d;
		c.start_x = COORD_W'($urandom_range(0, 63));
		c.start_y = COORD_W'($urandom_range(0, 63));
		c.end_x = COORD_W'($urandom_range(0, 63));
		c.end_y = COORD_W'($urandom_range(0, 63));
		c.draw_color = $urandom();
		case ($urandom_range(0, 9))
			0: begin
				c.end_x = c.start_x;
				c.end_y = c.start_y;
			end
			1: c.end_y = c.start_y;
			2: c.end_x = c.start_x;
			3: begin
				// equal extents in a random direction
				d = $urandom_range(0, 63 - ((c.start_x > c.start_y) ?
					int'(c.start_x) : int'(c.start_y)));
				c.end_x = COORD_W'(int'(c.start_x) + d);
				c.end_y = COORD_W'(int'(c.start_y) + d);
				if ($urandom_range(0, 1)) begin
					c.start_x = c.end_x;
					c.end_x = COORD_W'(int'(c.end_x) - d);
				end
			end
			4: begin
				c.end_x = c.start_x ^ 6'($urandom_range(0, 3));
				c.end_y = c.start_y ^ 6'($urandom_range(0, 3));
			end
			default: ;
		endcase
		return c;
	endfunction

	task automatic test_extremes();
		send_points(0, 0, 63, 63, 32'h0000_0000);
		send_points(63, 63, 0, 0, 32'hFFFF_FFFF);
		send_points(0, 63, 63, 0, 32'hA5A5_5A5A);
		send_points(63, 0, 0, 63, 32'h5A5A_A5A5);
		send_points(0, 0, 63, 0, 32'h8000_0001);
		send_points(0, 0, 0, 63, 32'h7FFF_FFFE);
		send_points(63, 63, 63, 0, 32'h0123_4567);
		send_points(63, 63, 0, 63, 32'h89AB_CDEF);
	endtask

	task automatic test_single_point();
		send_points(0, 0, 0, 0, 32'hDEAD_BEEF);
		send_points(63, 63, 63, 63, 32'hFFFF_FFFF);
		send_points(17, 42, 17, 42, 32'h0000_0000);
	endtask

	task automatic test_equal_extents();
		send_points(5, 5, 20, 20, 32'h1111_1111);
		send_points(20, 5, 5, 20, 32'h2222_2222);
		send_points(30, 40, 31, 41, 32'h3333_3333);
	endtask

	task automatic test_reversed_order();
		send_points(50, 10, 10, 20, 32'h4444_4444);
		send_points(10, 50, 20, 5, 32'h5555_5555);
		send_points(40, 3, 2, 7, 32'h6666_6666);
	endtask

	task automatic test_steep_lines();
		send_points(3, 0, 9, 63, 32'h7777_7777);
		send_points(60, 2, 58, 30, 32'h8888_8888);
		send_points(0, 1, 1, 3, 32'h9999_9999);
	endtask

	// sender holds off until the rasterizer has drained completely
	task automatic test_drain_pause();
		repeat (8) send_line(random_line());
		wait_drained();
		repeat (8) send_line(random_line());
		wait_drained();
	endtask

	task automatic test_random_lines(input int count);
		repeat (count) send_line(random_line());
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		pix_ready = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// sender mostly busy, receiver stalls often
		send_idle = 6;
		recv_idle = 57;
		test_extremes();
		test_single_point();
		test_equal_extents();
		test_reversed_order();
		test_steep_lines();
		test_random_lines(110);

		// sender idles often, receiver mostly ready
		send_idle = 57;
		recv_idle = 6;
		test_drain_pause();
		test_random_lines(110);

		// full throughput on both sides
		send_idle = 0;
		recv_idle = 0;
		test_random_lines(120);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && due_pixels.size() == 0) begin
			$display("line_rasterizer test passed");
		end else begin
			$display("line_rasterizer test failed");
		end
		$finish;
	end

endmodule
